// ----- rtl/core/gpam_pkg.sv -----
// Package for the gamepad axis merge core: configuration types, reset values,
// pad button bit positions and the divide-by-full-scale helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpam_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEADZONE      = 2'd0,
		REG_STICK_RANGE   = 2'd1,
		REG_TRIGGER_CLICK = 2'd2
	} cfg_reg_t;

	// Live configuration, shared by all conversion units
	typedef struct packed {
		logic [14:0] deadzone;
		logic [6:0]  stick_range;
		logic [14:0] trigger_click;
	} cfg_t;

	localparam logic [14:0] DEADZONE_RST      = 15'd4000;
	localparam logic [6:0]  STICK_RANGE_RST   = 7'd80;
	localparam logic [14:0] TRIGGER_CLICK_RST = 15'd30000;

	// Full-scale raw axis value and trigger output scale
	localparam logic [15:0] FULL_SCALE   = 16'd32767;
	localparam logic [7:0]  TRIG_SCALE   = 8'd255;

	// PAD button bit positions
	localparam int unsigned PAD_LEFT  = 0;
	localparam int unsigned PAD_RIGHT = 1;
	localparam int unsigned PAD_DOWN  = 2;
	localparam int unsigned PAD_UP    = 3;
	localparam int unsigned PAD_Z     = 4;
	localparam int unsigned PAD_R     = 5;
	localparam int unsigned PAD_L     = 6;
	localparam int unsigned PAD_A     = 8;
	localparam int unsigned PAD_B     = 9;
	localparam int unsigned PAD_X     = 10;
	localparam int unsigned PAD_Y     = 11;
	localparam int unsigned PAD_START = 12;

	// Raw button bit positions
	localparam int unsigned RAW_SOUTH = 0;
	localparam int unsigned RAW_EAST  = 1;
	localparam int unsigned RAW_WEST  = 2;
	localparam int unsigned RAW_NORTH = 3;
	localparam int unsigned RAW_START = 4;
	localparam int unsigned RAW_RSHLD = 5;
	localparam int unsigned RAW_LSHLD = 6;
	localparam int unsigned RAW_DLEFT = 7;
	localparam int unsigned RAW_DRGHT = 8;
	localparam int unsigned RAW_DDOWN = 9;
	localparam int unsigned RAW_DUP   = 10;

	// Divide a product by 32767, truncating. With p = q0*2^15 + r0 the
	// quotient is q0 plus one when q0 + r0 reaches 32767; the fold stays
	// below twice the divisor for products up to 23 bits.
	function automatic logic [8:0] div_full_scale(input logic [22:0] prod);
		logic [15:0] fold;
		fold = {8'd0, prod[22:15]} + {1'b0, prod[14:0]};
		return {1'b0, prod[22:15]} + {8'd0, (fold >= FULL_SCALE)};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gpam_stick.sv -----
// One stick axis: deadzone, scale to the stick range, clamp and merge with
// the keyboard axis. Depends on gpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpam_stick
	import gpam_pkg::*;
(
	input  wire logic [15:0] axis,
	input  wire logic        flip,
	input  wire logic [7:0]  kb_axis,
	input  wire cfg_t        cfg,
	output logic      [7:0]  value
);

	logic [16:0] mag_wide;
	logic [15:0] mag;
	logic        neg;
	logic [22:0] prod;
	logic [8:0]  quot;
	logic [7:0]  lim;
	logic [7:0]  sval;
	logic        dead;

	// Split into magnitude and sign; a flipped axis maps -32768 to +32768
	always_comb begin
		mag_wide = axis[15] ? (17'd0 - {axis[15], axis}) : {1'b0, axis};
		mag      = mag_wide[15:0];
		neg      = flip ? ((axis != 16'd0) && !axis[15]) : axis[15];
		dead     = (mag < {1'b0, cfg.deadzone});
	end

	// Scale magnitude by range/32767, clamp, restore sign
	always_comb begin
		prod = 23'(mag) * 23'(cfg.stick_range);
		quot = div_full_scale(prod);
		lim  = (quot > {2'b00, cfg.stick_range}) ? {1'b0, cfg.stick_range} : quot[7:0];
		sval = neg ? (8'd0 - lim) : lim;
	end

	// Pad fills only an axis the keyboard left at zero
	assign value = (!dead && (lim != 8'd0) && (kb_axis == 8'd0)) ? sval : kb_axis;

endmodule

`default_nettype wire

// ----- rtl/core/gpam_trigger.sv -----
// One analog trigger: scale to 0..255, merge with the keyboard trigger, and
// detect the digital click threshold. Depends on gpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpam_trigger
	import gpam_pkg::*;
(
	input  wire logic [15:0] trig,
	input  wire logic [7:0]  kb_trig,
	input  wire cfg_t        cfg,
	output logic      [7:0]  value,
	output logic             click
);

	logic [22:0] prod;
	logic [8:0]  quot;
	logic [7:0]  scaled;
	logic        pos;

	// Scale positive readings by 255/32767
	always_comb begin
		pos    = !trig[15] && (trig != 16'd0);
		prod   = 23'(trig[14:0]) * 23'(TRIG_SCALE);
		quot   = div_full_scale(prod);
		scaled = quot[8] ? TRIG_SCALE : quot[7:0];
	end

	// Fill a zero keyboard trigger; click on signed threshold compare
	assign value = (pos && (kb_trig == 8'd0)) ? scaled : kb_trig;
	assign click = ($signed({trig[15], trig}) >= $signed({2'b00, cfg.trigger_click}));

endmodule

`default_nettype wire

// ----- rtl/core/gpam_buttons.sv -----
// Button merge: map raw buttons to PAD bits, OR into the keyboard mask and
// cancel opposing d-pad directions. Depends on gpam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpam_buttons
	import gpam_pkg::*;
(
	input  wire logic [10:0] raw,
	input  wire logic [15:0] kb_mask,
	input  wire logic        l_click,
	input  wire logic        r_click,
	output logic      [15:0] mask
);

	logic [15:0] pad;

	// Build the pad contribution
	always_comb begin
		pad            = 16'd0;
		pad[PAD_A]     = raw[RAW_SOUTH];
		pad[PAD_B]     = raw[RAW_EAST];
		pad[PAD_X]     = raw[RAW_WEST];
		pad[PAD_Y]     = raw[RAW_NORTH];
		pad[PAD_START] = raw[RAW_START];
		pad[PAD_Z]     = raw[RAW_RSHLD];
		pad[PAD_L]     = raw[RAW_LSHLD] || l_click;
		pad[PAD_R]     = r_click;
		// Opposing directions cancel
		pad[PAD_LEFT]  = raw[RAW_DLEFT] && !raw[RAW_DRGHT];
		pad[PAD_RIGHT] = raw[RAW_DRGHT] && !raw[RAW_DLEFT];
		pad[PAD_DOWN]  = raw[RAW_DDOWN] && !raw[RAW_DUP];
		pad[PAD_UP]    = raw[RAW_DUP] && !raw[RAW_DDOWN];
	end

	assign mask = kb_mask | pad;

endmodule

`default_nettype wire

// ----- rtl/core/gamepad_axis_merge_core.sv -----
// Top level of the gamepad axis merge core: input register, conversion units,
// result register and configuration registers. Depends on gpam_pkg,
// gpam_stick, gpam_trigger and gpam_buttons.
`timescale 1ns / 1ps
`default_nettype none

// A reading is taken on any clock edge with start high and busy low; busy is
// high only in the first cycle after reset, so one reading can be issued every
// cycle. Each reading produces exactly one result: it is held in the input
// register, then passes through the stick/trigger scaling (a 16x7 or
// 15x8 multiply plus a fold-and-compare divide by 32767) into the result
// register. The result ports hold the merged frame for one cycle with done
// high and must be taken then; there is no back-pressure. Configuration writes
// are accepted whenever busy is low (cfg_ready follows !busy) and take effect
// on the next reading; indexes past the register list are ignored.
module gamepad_axis_merge_core
	import gpam_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] left_x,
	input  wire logic [15:0] left_y,
	input  wire logic [15:0] right_x,
	input  wire logic [15:0] right_y,
	input  wire logic [15:0] left_trig,
	input  wire logic [15:0] right_trig,
	input  wire logic [10:0] raw_buttons,
	input  wire logic [31:0] kb_sticks,
	input  wire logic [15:0] kb_triggers,
	input  wire logic [15:0] kb_buttons,
	// Result channel
	output logic             done,
	output logic [7:0]       stick_x,
	output logic [7:0]       stick_y,
	output logic [7:0]       sub_x,
	output logic [7:0]       sub_y,
	output logic [7:0]       analog_l,
	output logic [7:0]       analog_r,
	output logic [15:0]      buttons,
	// Configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	logic        busy_q;
	logic        take;
	cfg_t        cfg_q;

	logic        valid_s1;
	logic [15:0] left_x_s1, left_y_s1, right_x_s1, right_y_s1;
	logic [15:0] left_trig_s1, right_trig_s1;
	logic [10:0] raw_buttons_s1;
	logic [31:0] kb_sticks_s1;
	logic [15:0] kb_triggers_s1, kb_buttons_s1;

	logic [7:0]  sx, sy, cx, cy, tl, tr;
	logic        l_click, r_click;
	logic [15:0] btn;

	logic        done_s2;
	logic [7:0]  stick_x_s2, stick_y_s2, sub_x_s2, sub_y_s2;
	logic [7:0]  analog_l_s2, analog_r_s2;
	logic [15:0] buttons_s2;

	// Hold off commands for one cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign take      = start && !busy_q;
	assign cfg_ready = !busy_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone      <= DEADZONE_RST;
			cfg_q.stick_range   <= STICK_RANGE_RST;
			cfg_q.trigger_click <= TRIGGER_CLICK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEADZONE:      cfg_q.deadzone      <= cfg_data;
				REG_STICK_RANGE:   cfg_q.stick_range   <= cfg_data[6:0];
				REG_TRIGGER_CLICK: cfg_q.trigger_click <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (take) begin
			left_x_s1      <= left_x;
			left_y_s1      <= left_y;
			right_x_s1     <= right_x;
			right_y_s1     <= right_y;
			left_trig_s1   <= left_trig;
			right_trig_s1  <= right_trig;
			raw_buttons_s1 <= raw_buttons;
			kb_sticks_s1   <= kb_sticks;
			kb_triggers_s1 <= kb_triggers;
			kb_buttons_s1  <= kb_buttons;
		end
	end

	// Stick axes; Y axes point down and are flipped
	gpam_stick u_stick_x (
		.axis(left_x_s1), .flip(1'b0), .kb_axis(kb_sticks_s1[7:0]),
		.cfg(cfg_q), .value(sx)
	);
	gpam_stick u_stick_y (
		.axis(left_y_s1), .flip(1'b1), .kb_axis(kb_sticks_s1[15:8]),
		.cfg(cfg_q), .value(sy)
	);
	gpam_stick u_sub_x (
		.axis(right_x_s1), .flip(1'b0), .kb_axis(kb_sticks_s1[23:16]),
		.cfg(cfg_q), .value(cx)
	);
	gpam_stick u_sub_y (
		.axis(right_y_s1), .flip(1'b1), .kb_axis(kb_sticks_s1[31:24]),
		.cfg(cfg_q), .value(cy)
	);

	// Analog triggers
	gpam_trigger u_trig_l (
		.trig(left_trig_s1), .kb_trig(kb_triggers_s1[7:0]), .cfg(cfg_q),
		.value(tl), .click(l_click)
	);
	gpam_trigger u_trig_r (
		.trig(right_trig_s1), .kb_trig(kb_triggers_s1[15:8]), .cfg(cfg_q),
		.value(tr), .click(r_click)
	);

	// Buttons
	gpam_buttons u_buttons (
		.raw(raw_buttons_s1), .kb_mask(kb_buttons_s1), .l_click(l_click),
		.r_click(r_click), .mask(btn)
	);

	// Result register: strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			stick_x_s2  <= sx;
			stick_y_s2  <= sy;
			sub_x_s2    <= cx;
			sub_y_s2    <= cy;
			analog_l_s2 <= tl;
			analog_r_s2 <= tr;
			buttons_s2  <= btn;
		end
	end

	assign done     = done_s2;
	assign stick_x  = stick_x_s2;
	assign stick_y  = stick_y_s2;
	assign sub_x    = sub_x_s2;
	assign sub_y    = sub_y_s2;
	assign analog_l = analog_l_s2;
	assign analog_r = analog_r_s2;
	assign buttons  = buttons_s2;

	// Every accepted transaction passes the input register and reaches the result register
	a_take_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 done_s2)
		else $error("accepted transaction produced no result");

	// No result without a transaction in the input register
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 |-> $past(valid_s1))
		else $error("result without source transaction");

	// Busy only right after reset
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q)
		else $error("busy raised after reset");

	// Left shoulder or click always shows as L
	a_l_bit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (raw_buttons_s1[RAW_LSHLD] || l_click) |=> buttons_s2[PAD_L])
		else $error("L bit missing");

endmodule

`default_nettype wire
